/* rtl/sdhct_pkg.sv */
// Shared types and codes for the SD host completion tracker.
package sdhct_pkg;

  localparam logic [1:0] MODE_START  = 2'd0;
  localparam logic [1:0] MODE_STATUS = 2'd1;
  localparam logic [1:0] MODE_DMA    = 2'd2;

  localparam logic [2:0] AW_NONE = 3'd0;
  localparam logic [2:0] AW_SENT = 3'd1;
  localparam logic [2:0] AW_RSP  = 3'd2;
  localparam logic [2:0] AW_XFER = 3'd3;
  localparam logic [2:0] AW_BOTH = 3'd4;

  localparam logic [1:0] CMD_ERR_NONE    = 2'd0;
  localparam logic [1:0] CMD_ERR_TIMEOUT = 2'd1;
  localparam logic [1:0] CMD_ERR_CRC     = 2'd2;

  localparam logic [2:0] DATA_ERR_NONE    = 3'd0;
  localparam logic [2:0] DATA_ERR_FIFO    = 3'd1;
  localparam logic [2:0] DATA_ERR_CRC     = 3'd2;
  localparam logic [2:0] DATA_ERR_TIMEOUT = 3'd3;
  localparam logic [2:0] DATA_ERR_DMA     = 3'd4;

  localparam int CS_TIMEOUT  = 0;
  localparam int CS_SENT     = 1;
  localparam int CS_RSP_CRC  = 2;
  localparam int CS_RSP_DONE = 3;

  localparam int DS_FIFO    = 0;
  localparam int DS_RX_CRC  = 1;
  localparam int DS_TX_CRC  = 2;
  localparam int DS_TIMEOUT = 3;
  localparam int DS_FINISH  = 4;

  typedef struct packed {
    logic [1:0] mode;
    logic       wants_response;
    logic       response_crc;
    logic       has_data;
    logic       is_read;
    logic [3:0] cmd_status;
    logic [4:0] data_status;
    logic       dma_ok;
    logic       data_left;
  } req_t;

  typedef struct packed {
    logic       done_res;
    logic [1:0] cmd_error;
    logic [2:0] data_error;
    logic [3:0] cmd_ack_bits;
    logic [4:0] data_ack_bits;
    logic       irq_disable;
  } rsp_t;

  typedef struct packed {
    logic [2:0] awaited;
    logic       held;
    logic       need_crc;
    logic       data_phase;
    logic       reading;
    logic [1:0] cmd_err;
    logic [2:0] data_err;
    logic       dma_seen;
  } state_t;

endpackage

/* rtl/sdhct_if.sv */
// Valid/ready channel interfaces for request and result items.
interface sdhct_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       wants_response;
  logic       response_crc;
  logic       has_data;
  logic       is_read;
  logic [3:0] cmd_status;
  logic [4:0] data_status;
  logic       dma_ok;
  logic       data_left;

  modport source (
    output valid, mode, wants_response, response_crc, has_data, is_read,
           cmd_status, data_status, dma_ok, data_left,
    input  ready
  );
  modport sink (
    input  valid, mode, wants_response, response_crc, has_data, is_read,
           cmd_status, data_status, dma_ok, data_left,
    output ready
  );
endinterface

interface sdhct_rsp_if;
  logic       valid;
  logic       ready;
  logic       done_res;
  logic [1:0] cmd_error;
  logic [2:0] data_error;
  logic [3:0] cmd_ack_bits;
  logic [4:0] data_ack_bits;
  logic       irq_disable;

  modport source (
    output valid, done_res, cmd_error, data_error, cmd_ack_bits, data_ack_bits,
           irq_disable,
    input  ready
  );
  modport sink (
    input  valid, done_res, cmd_error, data_error, cmd_ack_bits, data_ack_bits,
           irq_disable,
    output ready
  );
endinterface

/* rtl/sdhct_logic.sv */
// Next-state and result decode for one request item.
module sdhct_logic
  import sdhct_pkg::*;
(
  input  req_t   item,
  input  state_t st,
  output state_t st_next,
  output rsp_t   res
);

  logic       fin;
  logic       done;
  logic       irq;
  logic [3:0] cack;
  logic [4:0] dack;
  state_t     nxt;

  always_comb begin
    fin  = 1'b0;
    done = 1'b0;
    irq  = 1'b0;
    cack = '0;
    dack = '0;
    nxt  = st;
    case (item.mode)
      MODE_START: begin
        nxt.need_crc   = item.response_crc;
        nxt.data_phase = item.has_data;
        nxt.reading    = item.is_read;
        if (item.has_data) begin
          nxt.awaited = AW_BOTH;
        end else if (item.wants_response) begin
          nxt.awaited = AW_RSP;
        end else begin
          nxt.awaited = AW_SENT;
        end
        nxt.held     = 1'b1;
        nxt.dma_seen = 1'b0;
        nxt.cmd_err  = CMD_ERR_NONE;
        nxt.data_err = DATA_ERR_NONE;
        cack = '1;
        dack = '1;
      end
      MODE_STATUS: begin
        if (st.awaited == AW_NONE || !st.held) begin
          irq = 1'b1;
        end else begin
          if (item.cmd_status[CS_TIMEOUT]) begin
            nxt.cmd_err = CMD_ERR_TIMEOUT;
            fin = 1'b1;
          end
          if (!fin && item.cmd_status[CS_SENT]) begin
            if (nxt.awaited == AW_SENT) begin
              nxt.cmd_err = CMD_ERR_NONE;
              fin = 1'b1;
            end else begin
              cack[CS_SENT] = 1'b1;
            end
          end
          if (!fin && item.cmd_status[CS_RSP_CRC]) begin
            if (nxt.need_crc) begin
              nxt.cmd_err = CMD_ERR_CRC;
              fin = 1'b1;
            end else begin
              cack[CS_RSP_CRC] = 1'b1;
            end
          end
          if (!fin && item.cmd_status[CS_RSP_DONE]) begin
            if (nxt.awaited == AW_RSP) begin
              nxt.cmd_err = CMD_ERR_NONE;
              fin = 1'b1;
            end else begin
              if (nxt.awaited == AW_BOTH) begin
                nxt.cmd_err = CMD_ERR_NONE;
                nxt.awaited = AW_XFER;
              end
              cack[CS_RSP_DONE] = 1'b1;
            end
          end
          if (!fin && item.data_status[DS_FIFO]) begin
            nxt.cmd_err  = CMD_ERR_NONE;
            nxt.data_err = DATA_ERR_FIFO;
            fin = 1'b1;
          end
          if (!fin && (item.data_status[DS_RX_CRC] || item.data_status[DS_TX_CRC])) begin
            nxt.cmd_err  = CMD_ERR_NONE;
            nxt.data_err = DATA_ERR_CRC;
            fin = 1'b1;
          end
          if (!fin && item.data_status[DS_TIMEOUT]) begin
            nxt.cmd_err  = CMD_ERR_NONE;
            nxt.data_err = DATA_ERR_TIMEOUT;
            fin = 1'b1;
          end
          if (!fin && item.data_status[DS_FINISH]) begin
            if (nxt.awaited == AW_XFER) begin
              nxt.cmd_err  = CMD_ERR_NONE;
              nxt.data_err = DATA_ERR_NONE;
              fin = 1'b1;
            end else begin
              if (nxt.awaited == AW_BOTH) begin
                nxt.data_err = DATA_ERR_NONE;
                nxt.awaited  = AW_RSP;
              end
              dack[DS_FINISH] = 1'b1;
            end
          end
          if (fin) begin
            nxt.awaited = AW_NONE;
            if (!nxt.data_phase || nxt.dma_seen) begin
              nxt.held = 1'b0;
            end
            done = 1'b1;
            irq  = 1'b1;
            cack = '0;
            dack = '0;
          end
        end
      end
      MODE_DMA: begin
        if (st.held && st.data_phase) begin
          nxt.dma_seen = 1'b1;
          if (!item.dma_ok || (st.reading && item.data_left)) begin
            nxt.data_err = DATA_ERR_DMA;
            nxt.awaited  = AW_NONE;
            done = 1'b1;
            irq  = 1'b1;
          end
          if (nxt.awaited == AW_NONE) begin
            nxt.held = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign st_next           = nxt;
  assign res.done_res      = done;
  assign res.cmd_error     = nxt.cmd_err;
  assign res.data_error    = nxt.data_err;
  assign res.cmd_ack_bits  = cack;
  assign res.data_ack_bits = dack;
  assign res.irq_disable   = irq;

endmodule

/* rtl/sdhct_out_reg.sv */
// Result register driving the output channel.
module sdhct_out_reg
  import sdhct_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  rsp_t            res,
  output logic            space,
  sdhct_rsp_if.source     rsp
);

  logic valid;
  rsp_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign space             = !valid || rsp.ready;
  assign rsp.valid         = valid;
  assign rsp.done_res      = data.done_res;
  assign rsp.cmd_error     = data.cmd_error;
  assign rsp.data_error    = data.data_error;
  assign rsp.cmd_ack_bits  = data.cmd_ack_bits;
  assign rsp.data_ack_bits = data.data_ack_bits;
  assign rsp.irq_disable   = data.irq_disable;

endmodule

/* rtl/sd_host_completion_tracker_unit.sv */
// Top level: SD host request completion tracker.
// An accepted item's result is in the output register in the cycle after acceptance.
// Throughput: one item per cycle while results are taken; the output register takes
// a new result in the cycle its current one is taken.
// Reset (rst, synchronous): tracker state cleared, nothing awaited, no result
// pending.
module sd_host_completion_tracker_unit
  import sdhct_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sdhct_req_if.sink   req,
  sdhct_rsp_if.source rsp
);

  state_t st;
  state_t st_next;
  req_t   item;
  rsp_t   res;
  logic   space;
  logic   in_acc;

  assign item.mode           = req.mode;
  assign item.wants_response = req.wants_response;
  assign item.response_crc   = req.response_crc;
  assign item.has_data       = req.has_data;
  assign item.is_read        = req.is_read;
  assign item.cmd_status     = req.cmd_status;
  assign item.data_status    = req.data_status;
  assign item.dma_ok         = req.dma_ok;
  assign item.data_left      = req.data_left;

  assign req.ready = space;
  assign in_acc    = req.valid && space;

  sdhct_logic u_logic (
    .item    (item),
    .st      (st),
    .st_next (st_next),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_acc) begin
      st <= st_next;
    end
  end

  sdhct_out_reg u_out_reg (
    .clk   (clk),
    .rst   (rst),
    .load  (in_acc),
    .res   (res),
    .space (space),
    .rsp   (rsp)
  );

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> rsp.valid)
    else $error("accepted item produced no result");

  a_start_clears_all: assert property (@(posedge clk) disable iff (rst)
    in_acc && req.mode == MODE_START |=>
      rsp.cmd_ack_bits == 4'hF && rsp.data_ack_bits == 5'h1F && !rsp.done_res)
    else $error("start item result wrong");

  a_done_no_ack: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.done_res |-> rsp.cmd_ack_bits == '0 && rsp.data_ack_bits == '0
      && rsp.irq_disable)
    else $error("closing result acknowledges status");

  a_unheld_idle: assert property (@(posedge clk) disable iff (rst)
    !st.held |-> st.awaited == AW_NONE)
    else $error("event awaited with no request held");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp.valid)
    else $error("result pending after reset");

endmodule

/* test/tb_sd_host_completion_tracker_unit.sv */
// Self-checking testbench for the SD host completion tracker: directed table, then random items.
module tb_sd_host_completion_tracker_unit;
  import sdhct_pkg::*;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int DIR_ROWS = 28;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES = 40;
  localparam int QUIET_LIMIT = 4000;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [2:0] waiting;
    logic       held;
    logic       crc_check;
    logic       xfer;
    logic       rd;
    logic [1:0] cmd_code;
    logic [2:0] data_code;
    logic       dma_done;
  } tracker_t;

  typedef struct packed {
    req_t item;
    logic typed;
    rsp_t golden;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  sdhct_req_if req_ch();
  sdhct_rsp_if rsp_ch();

  sd_host_completion_tracker_unit u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  tracker_t   trk;
  rsp_t       pending_res[$];
  rsp_t       due;
  dir_row_t   dir_tab[DIR_ROWS];
  idle_mode_t idle_mode;
  int errors = 0;
  int results = 0;
  int starts = 0;
  int closes = 0;
  int cmd_faults = 0;
  int data_faults = 0;
  int quiet = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  function automatic rsp_t res(logic done, logic [1:0] ce, logic [2:0] de, logic [3:0] ca,
                               logic [4:0] da, logic irq);
    return {done, ce, de, ca, da, irq};
  endfunction

  function automatic req_t mk_start(logic rsp, logic crc, logic data, logic rd);
    req_t r;
    r = '0;
    r.mode = MODE_START;
    r.wants_response = rsp;
    r.response_crc = crc;
    r.has_data = data;
    r.is_read = rd;
    return r;
  endfunction

  function automatic req_t mk_status(logic [3:0] cs, logic [4:0] ds);
    req_t r;
    r = '0;
    r.mode = MODE_STATUS;
    r.cmd_status = cs;
    r.data_status = ds;
    return r;
  endfunction

  function automatic req_t mk_dma(logic ok, logic left);
    req_t r;
    r = '0;
    r.mode = MODE_DMA;
    r.dma_ok = ok;
    r.data_left = left;
    return r;
  endfunction

  // Predicts one result and advances the tracker state.
  function automatic rsp_t track_item(input req_t it);
    rsp_t r;
    logic fin;
    r = '0;
    fin = 1'b0;
    case (it.mode)
      MODE_START: begin
        trk.crc_check = it.response_crc;
        trk.xfer = it.has_data;
        trk.rd = it.is_read;
        if (it.has_data) trk.waiting = AW_BOTH;
        else if (it.wants_response) trk.waiting = AW_RSP;
        else trk.waiting = AW_SENT;
        trk.held = 1'b1;
        trk.dma_done = 1'b0;
        trk.cmd_code = CMD_ERR_NONE;
        trk.data_code = DATA_ERR_NONE;
        r.cmd_ack_bits = '1;
        r.data_ack_bits = '1;
      end
      MODE_STATUS: begin
        if (trk.waiting == AW_NONE || !trk.held) begin
          r.irq_disable = 1'b1;
        end else begin
          if (it.cmd_status[CS_TIMEOUT]) begin
            trk.cmd_code = CMD_ERR_TIMEOUT;
            fin = 1'b1;
          end
          if (!fin && it.cmd_status[CS_SENT]) begin
            if (trk.waiting == AW_SENT) begin
              trk.cmd_code = CMD_ERR_NONE;
              fin = 1'b1;
            end else r.cmd_ack_bits[CS_SENT] = 1'b1;
          end
          if (!fin && it.cmd_status[CS_RSP_CRC]) begin
            if (trk.crc_check) begin
              trk.cmd_code = CMD_ERR_CRC;
              fin = 1'b1;
            end else r.cmd_ack_bits[CS_RSP_CRC] = 1'b1;
          end
          if (!fin && it.cmd_status[CS_RSP_DONE]) begin
            if (trk.waiting == AW_RSP) begin
              trk.cmd_code = CMD_ERR_NONE;
              fin = 1'b1;
            end else begin
              if (trk.waiting == AW_BOTH) begin
                trk.cmd_code = CMD_ERR_NONE;
                trk.waiting = AW_XFER;
              end
              r.cmd_ack_bits[CS_RSP_DONE] = 1'b1;
            end
          end
          if (!fin && it.data_status[DS_FIFO]) begin
            trk.cmd_code = CMD_ERR_NONE;
            trk.data_code = DATA_ERR_FIFO;
            fin = 1'b1;
          end
          if (!fin && (it.data_status[DS_RX_CRC] || it.data_status[DS_TX_CRC])) begin
            trk.cmd_code = CMD_ERR_NONE;
            trk.data_code = DATA_ERR_CRC;
            fin = 1'b1;
          end
          if (!fin && it.data_status[DS_TIMEOUT]) begin
            trk.cmd_code = CMD_ERR_NONE;
            trk.data_code = DATA_ERR_TIMEOUT;
            fin = 1'b1;
          end
          if (!fin && it.data_status[DS_FINISH]) begin
            if (trk.waiting == AW_XFER) begin
              trk.cmd_code = CMD_ERR_NONE;
              trk.data_code = DATA_ERR_NONE;
              fin = 1'b1;
            end else begin
              if (trk.waiting == AW_BOTH) begin
                trk.data_code = DATA_ERR_NONE;
                trk.waiting = AW_RSP;
              end
              r.data_ack_bits[DS_FINISH] = 1'b1;
            end
          end
          if (fin) begin
            trk.waiting = AW_NONE;
            if (!trk.xfer || trk.dma_done) trk.held = 1'b0;
            r.done_res = 1'b1;
            r.irq_disable = 1'b1;
            r.cmd_ack_bits = '0;
            r.data_ack_bits = '0;
          end
        end
      end
      MODE_DMA: begin
        if (trk.held && trk.xfer) begin
          trk.dma_done = 1'b1;
          if (!it.dma_ok || (trk.rd && it.data_left)) begin
            trk.data_code = DATA_ERR_DMA;
            trk.waiting = AW_NONE;
            r.done_res = 1'b1;
            r.irq_disable = 1'b1;
          end
          if (trk.waiting == AW_NONE) trk.held = 1'b0;
        end
      end
      default: ;
    endcase
    r.cmd_error = trk.cmd_code;
    r.data_error = trk.data_code;
    return r;
  endfunction

  // Status bits are kept sparse so that priority chains get past their first checks.
  function automatic req_t rand_item(input logic [1:0] mode);
    req_t r;
    logic [31:0] rnd;
    rnd = $urandom;
    r = rnd[$bits(req_t)-1:0];
    r.mode = mode;
    if (mode == MODE_STATUS) begin
      for (int b = 0; b < 4; b++) r.cmd_status[b] = ($urandom_range(0, 3) == 0);
      for (int b = 0; b < 5; b++) r.data_status[b] = ($urandom_range(0, 4) == 0);
    end
    if (mode == MODE_DMA) r.dma_ok = ($urandom_range(0, 3) != 0);
    return r;
  endfunction

  function automatic logic src_idles();
    case (idle_mode)
      IDLE_SRC:  return $urandom_range(0, 99) < 87;
      IDLE_BOTH: return $urandom_range(0, 99) < 13;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic snk_stalls();
    case (idle_mode)
      IDLE_SNK:  return $urandom_range(0, 99) < 87;
      IDLE_BOTH: return $urandom_range(0, 99) < 13;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic put_fields(input req_t it);
    req_ch.mode = it.mode;
    req_ch.wants_response = it.wants_response;
    req_ch.response_crc = it.response_crc;
    req_ch.has_data = it.has_data;
    req_ch.is_read = it.is_read;
    req_ch.cmd_status = it.cmd_status;
    req_ch.data_status = it.data_status;
    req_ch.dma_ok = it.dma_ok;
    req_ch.data_left = it.data_left;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input req_t it, input logic typed, input rsp_t golden);
    rsp_t r;
    while (src_idles()) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    put_fields(it);
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    r = track_item(it);
    pending_res.push_back(typed ? golden : r);
    if (it.mode == MODE_START) starts++;
    @(negedge clk);
  endtask

  task automatic cmp(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready = 1'b0;
    end else if (hold_asked != hold_served) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = !snk_stalls();
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results++;
      if (pending_res.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        due = pending_res.pop_front();
        cmp("done_res", due.done_res, rsp_ch.done_res);
        cmp("cmd_error", due.cmd_error, rsp_ch.cmd_error);
        cmp("data_error", due.data_error, rsp_ch.data_error);
        cmp("cmd_ack_bits", due.cmd_ack_bits, rsp_ch.cmd_ack_bits);
        cmp("data_ack_bits", due.data_ack_bits, rsp_ch.data_ack_bits);
        cmp("irq_disable", due.irq_disable, rsp_ch.irq_disable);
        if (rsp_ch.done_res) closes++;
        if (rsp_ch.done_res && rsp_ch.cmd_error != CMD_ERR_NONE) cmd_faults++;
        if (rsp_ch.done_res && rsp_ch.data_error != DATA_ERR_NONE) data_faults++;
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_sd_host_completion_tracker_unit: FAIL");
      $finish;
    end
  end

  initial begin
    req_t it;
    int   sent;
    int   n;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    rsp_ch.ready = 1'b0;
    put_fields('0);
    trk = '0;
    idle_mode = IDLE_NONE;
    dir_tab = '{
      '{mk_status(4'hf, 5'h1f), 1'b1, res(0, 0, 0, 0, 0, 1)},
      '{mk_dma(1'b0, 1'b1), 1'b1, res(0, 0, 0, 0, 0, 0)},
      '{{MODE_IGNORED, 15'h7fff}, 1'b1, res(0, 0, 0, 0, 0, 0)},
      '{mk_start(0, 0, 0, 0), 1'b1, res(0, 0, 0, 4'hf, 5'h1f, 0)},
      '{mk_status(4'b0001, 0), 1'b1, res(1, CMD_ERR_TIMEOUT, 0, 0, 0, 1)},
      '{mk_start(1, 1, 0, 0), 1'b1, res(0, 0, 0, 4'hf, 5'h1f, 0)},
      '{mk_status(4'b0100, 0), 1'b1, res(1, CMD_ERR_CRC, 0, 0, 0, 1)},
      '{mk_start(1, 0, 0, 0), 1'b1, res(0, 0, 0, 4'hf, 5'h1f, 0)},
      '{mk_status(4'b0110, 0), 1'b0, '0},
      '{mk_status(4'b1000, 0), 1'b0, '0},
      '{mk_start(1, 1, 1, 1), 1'b1, res(0, 0, 0, 4'hf, 5'h1f, 0)},
      '{mk_status(4'b1000, 0), 1'b0, '0},
      '{mk_status(0, 5'b10000), 1'b0, '0},
      '{mk_dma(1'b1, 1'b1), 1'b0, '0},
      '{mk_start(0, 0, 1, 0), 1'b1, res(0, 0, 0, 4'hf, 5'h1f, 0)},
      '{mk_status(0, 5'b00001), 1'b1, res(1, 0, DATA_ERR_FIFO, 0, 0, 1)},
      '{mk_start(0, 0, 1, 0), 1'b1, res(0, 0, 0, 4'hf, 5'h1f, 0)},
      '{mk_status(0, 5'b00100), 1'b1, res(1, 0, DATA_ERR_CRC, 0, 0, 1)},
      '{mk_start(0, 1, 1, 1), 1'b1, res(0, 0, 0, 4'hf, 5'h1f, 0)},
      '{mk_status(0, 5'b01000), 1'b1, res(1, 0, DATA_ERR_TIMEOUT, 0, 0, 1)},
      '{mk_start(1, 0, 0, 0), 1'b1, res(0, 0, 0, 4'hf, 5'h1f, 0)},
      '{mk_status(0, 5'b00001), 1'b0, '0},
      '{mk_start(1, 0, 1, 1), 1'b1, res(0, 0, 0, 4'hf, 5'h1f, 0)},
      '{mk_status(0, 5'b10000), 1'b0, '0},
      '{mk_dma(1'b1, 1'b0), 1'b0, '0},
      '{mk_status(4'b1000, 0), 1'b0, '0},
      '{mk_start(0, 0, 1, 1), 1'b1, res(0, 0, 0, 4'hf, 5'h1f, 0)},
      '{mk_dma(1'b0, 1'b0), 1'b1, res(1, 0, DATA_ERR_DMA, 0, 0, 1)}
    };
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].golden);
    req_ch.valid = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_mode = idle_mode_t'((sent / 40) % 4);
      if (sent >= 250 && hold_asked == 0) begin
        // long sink hold-off with a back-to-back burst behind it
        idle_mode = IDLE_NONE;
        hold_asked++;
        for (int k = 0; k < 12; k++) begin
          send_item(rand_item(k == 0 ? MODE_START : MODE_STATUS), 1'b0, '0);
          sent++;
        end
      end else if ($urandom_range(0, 9) == 0) begin
        it = rand_item(2'($urandom_range(0, 3)));
        it.cmd_status = 4'($urandom);
        it.data_status = 5'($urandom);
        send_item(it, 1'b0, '0);
        if (it.mode != MODE_IGNORED) sent++;
      end else begin
        send_item(rand_item(MODE_START), 1'b0, '0);
        sent++;
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
          send_item(rand_item($urandom_range(0, 3) == 0 ? MODE_DMA : MODE_STATUS), 1'b0, '0);
          sent++;
        end
      end
    end
    req_ch.valid = 1'b0;
    idle_mode = IDLE_NONE;

    while (pending_res.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    $display("run covered %0d results over %0d requests: %0d closed, %0d with command error,",
             results, starts, closes, cmd_faults);
    $display("%0d with data error, under all idle and stall phases plus a long sink hold-off",
             data_faults);
    if (errors == 0) begin
      $display("tb_sd_host_completion_tracker_unit: PASS");
    end else begin
      $display("tb_sd_host_completion_tracker_unit: FAIL");
    end
    $finish;
  end

endmodule
